// File: rtl/core/bdn_pkg.sv
package bdn_pkg;

  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int MAX_CLASSES        = 4;
  localparam int CLASS_LIM          = (MAX_CLASSES < 4) ? MAX_CLASSES : 4;
  localparam int RESULT_LIMIT       = 64;
  localparam int KEPT_W             = 7;
  localparam int CFG_W              = 20;
  localparam int IDX_W              = 3;
  localparam int QUEUE_DEPTH        = 4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CONF    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OVERLAP = 3'd1;
  localparam logic [IDX_W-1:0] REG_INV     = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAD_X   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAD_Y   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAME_W = 3'd5;
  localparam logic [IDX_W-1:0] REG_FRAME_H = 3'd6;
  localparam logic [IDX_W-1:0] REG_CLASSES = 3'd7;

  typedef struct packed {
    logic [15:0] conf_threshold;
    logic [15:0] overlap_threshold;
    logic [19:0] inv_scale;
    logic [12:0] pad_x;
    logic [12:0] pad_y;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [2:0]  class_count;
  } cfg_t;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic [15:0] score;
  } cand_t;

  typedef struct packed {
    logic  keep;
    logic  last;
    cand_t cand;
  } qitem_t;

  typedef struct packed {
    cand_t cand;
    logic  last;
    logic  nodet;
    logic  ovf;
  } res_t;

endpackage

// File: rtl/core/box_decode_nms.sv
// Channel   Direction  Handshake              Payload
// config    in         cfg_we                 cfg_index, cfg_data
// predict   in         start (taken if !busy) center_x .. score_d, last_prediction
// result    out        result_valid (1 cycle) out_x .. out_score, flags
//
// Decode steps through F_MX and F_MY (two multiply steps), then F_OUT; busy is high meanwhile
// and stays high while F_OUT waits for room in the full 4-entry queue to the store.
// Store insert walks the sorted store one entry per B_CHK/B_CMP pass (one memory read port).
// Suppression runs N_J, N_JRD, N_MUL, N_UNI, N_THR, N_CMP for each pair of live candidates.
// rst is synchronous; it empties the store and restores register defaults.
// Results cannot be held off by the receiver.
module box_decode_nms #(
  parameter int MAX_CANDIDATES = bdn_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bdn_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bdn_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [13:0]                center_x,
  input  logic [13:0]                center_y,
  input  logic [13:0]                box_width_in,
  input  logic [13:0]                box_height_in,
  input  logic [15:0]                score_a,
  input  logic [15:0]                score_b,
  input  logic [15:0]                score_c,
  input  logic [15:0]                score_d,
  input  logic                       last_prediction,
  output logic                       result_valid,
  output logic [15:0]                out_x,
  output logic [15:0]                out_y,
  output logic [15:0]                out_w,
  output logic [15:0]                out_h,
  output logic [15:0]                out_score,
  output logic                       last_result,
  output logic                       no_detections,
  output logic                       store_overflow
);

  bdn_pkg::cfg_t   cfg;
  bdn_pkg::qitem_t q_in, q_out;
  bdn_pkg::res_t   res;
  logic            q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold    <= 16'd16384;
      cfg.overlap_threshold <= 16'd29491;
      cfg.inv_scale         <= 20'd65536;
      cfg.pad_x             <= '0;
      cfg.pad_y             <= '0;
      cfg.frame_width       <= 12'd640;
      cfg.frame_height      <= 12'd640;
      cfg.class_count       <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bdn_pkg::REG_CONF:    cfg.conf_threshold    <= cfg_data[15:0];
        bdn_pkg::REG_OVERLAP: cfg.overlap_threshold <= cfg_data[15:0];
        bdn_pkg::REG_INV:     cfg.inv_scale         <= cfg_data;
        bdn_pkg::REG_PAD_X:   cfg.pad_x             <= cfg_data[12:0];
        bdn_pkg::REG_PAD_Y:   cfg.pad_y             <= cfg_data[12:0];
        bdn_pkg::REG_FRAME_W: cfg.frame_width       <= cfg_data[11:0];
        bdn_pkg::REG_FRAME_H: cfg.frame_height      <= cfg_data[11:0];
        bdn_pkg::REG_CLASSES: cfg.class_count       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  bdn_front u_front (
    .clk, .rst, .cfg, .start,
    .center_x, .center_y, .box_width_in, .box_height_in,
    .score_a, .score_b, .score_c, .score_d, .last_prediction,
    .busy, .q_full, .q_push, .q_item(q_in)
  );

  bdn_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_in), .pop(q_pop), .dout(q_out),
    .full(q_full), .empty(q_empty)
  );

  bdn_back #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_back (
    .clk, .rst, .cfg, .q_empty, .q_item(q_out), .q_pop,
    .res_valid(result_valid), .res
  );

  assign out_x          = res.cand.box.x;
  assign out_y          = res.cand.box.y;
  assign out_w          = res.cand.box.w;
  assign out_h          = res.cand.box.h;
  assign out_score      = res.cand.score;
  assign last_result    = res.last;
  assign no_detections  = res.nodet;
  assign store_overflow = res.ovf;

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    result_valid && no_detections |-> last_result && out_w == 16'd0 && out_score == 16'd0)
    else $error("empty marker malformed");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_frame_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid)
    else $error("result right after frame end");

endmodule

// File: rtl/core/bdn_front.sv
module bdn_front (
  input  logic                 clk,
  input  logic                 rst,
  input  bdn_pkg::cfg_t        cfg,
  input  logic                 start,
  input  logic [13:0]          center_x,
  input  logic [13:0]          center_y,
  input  logic [13:0]          box_width_in,
  input  logic [13:0]          box_height_in,
  input  logic [15:0]          score_a,
  input  logic [15:0]          score_b,
  input  logic [15:0]          score_c,
  input  logic [15:0]          score_d,
  input  logic                 last_prediction,
  output logic                 busy,
  input  logic                 q_full,
  output logic                 q_push,
  output bdn_pkg::qitem_t      q_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MX   = 2'd1;
  localparam logic [1:0] F_MY   = 2'd2;
  localparam logic [1:0] F_OUT  = 2'd3;

  localparam int CLASS_LIM_V = bdn_pkg::CLASS_LIM;

  logic [1:0]  state;
  logic [13:0] cx, cy, bw, bh;
  logic [15:0] best;
  logic        pass, last;
  logic [34:0] px, py;
  logic [33:0] pw, ph;
  logic [15:0] x, w;

  logic [2:0]  cnt;
  logic [15:0] best_c;
  logic [14:0] dx, dy;
  logic [15:0] fw16, fh16;
  logic [15:0] y_c, h_c, x_c, w_c;
  logic        keep_c;

  function automatic logic [15:0] edge_fix(input logic [34:0] p, input logic [15:0] lim);
    logic [35:0] s;
    logic [18:0] e;
    s = {1'b0, p} + 36'd65536;
    e = s[35:17];
    edge_fix = (e > {3'b0, lim}) ? lim : e[15:0];
  endfunction

  function automatic logic [15:0] size_fix(input logic [33:0] p, input logic [15:0] lim);
    logic [34:0] s;
    logic [18:0] e;
    s = {1'b0, p} + 35'd32768;
    e = s[34:16];
    size_fix = (e > {3'b0, lim}) ? lim : e[15:0];
  endfunction

  function automatic logic [14:0] diff2(input logic [13:0] c, input logic [13:0] sz,
                                        input logic [12:0] pad);
    logic [14:0] pos, neg;
    pos = {c, 1'b0};
    neg = {1'b0, sz} + {1'b0, pad, 1'b0};
    diff2 = (pos > neg) ? pos - neg : 15'd0;
  endfunction

  always_comb begin
    cnt = cfg.class_count;
    if (cnt == 3'd0) cnt = 3'd1;
    if (cnt > 3'(CLASS_LIM_V)) cnt = 3'(CLASS_LIM_V);
    best_c = score_a;
    if (cnt >= 3'd2 && score_b > best_c) best_c = score_b;
    if (cnt >= 3'd3 && score_c > best_c) best_c = score_c;
    if (cnt >= 3'd4 && score_d > best_c) best_c = score_d;
  end

  assign dx   = diff2(cx, bw, cfg.pad_x);
  assign dy   = diff2(cy, bh, cfg.pad_y);
  assign fw16 = {cfg.frame_width, 4'b0};
  assign fh16 = {cfg.frame_height, 4'b0};
  assign x_c  = edge_fix(px, fw16);
  assign w_c  = size_fix(pw, fw16 - x_c);
  assign y_c  = edge_fix(py, fh16);
  assign h_c  = size_fix(ph, fh16 - y_c);
  assign keep_c = pass && (w > 16'd16) && (h_c > 16'd16);

  assign busy = (state != F_IDLE);
  assign q_push = (state == F_OUT) && !q_full && (keep_c || last);

  always_comb begin
    q_item.keep           = keep_c;
    q_item.last           = last;
    q_item.cand.box.x     = x;
    q_item.cand.box.y     = y_c;
    q_item.cand.box.w     = w;
    q_item.cand.box.h     = h_c;
    q_item.cand.score     = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (start) begin
          cx    <= center_x;
          cy    <= center_y;
          bw    <= box_width_in;
          bh    <= box_height_in;
          best  <= best_c;
          pass  <= best_c >= cfg.conf_threshold;
          last  <= last_prediction;
          state <= F_MX;
        end
        F_MX: begin
          px    <= {20'b0, dx} * {15'b0, cfg.inv_scale};
          pw    <= {20'b0, bw} * {14'b0, cfg.inv_scale};
          state <= F_MY;
        end
        F_MY: begin
          py    <= {20'b0, dy} * {15'b0, cfg.inv_scale};
          ph    <= {20'b0, bh} * {14'b0, cfg.inv_scale};
          x     <= x_c;
          w     <= w_c;
          state <= F_OUT;
        end
        F_OUT: if (!q_full || !(keep_c || last)) begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/bdn_queue.sv
module bdn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bdn_pkg::qitem_t din,
  input  logic            pop,
  output bdn_pkg::qitem_t dout,
  output logic            full,
  output logic            empty
);

  localparam int D  = bdn_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  bdn_pkg::qitem_t slots [D];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(D));
  assign empty = (count == '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// File: rtl/core/bdn_back.sv
module bdn_back #(
  parameter int MAX_CANDIDATES = bdn_pkg::MAX_CANDIDATES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bdn_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  bdn_pkg::qitem_t q_item,
  output logic            q_pop,
  output logic            res_valid,
  output bdn_pkg::res_t   res
);

  localparam int AW = $clog2(MAX_CANDIDATES);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int KW = bdn_pkg::KEPT_W;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_FULL  = 4'd1;
  localparam logic [3:0] B_FCMP  = 4'd2;
  localparam logic [3:0] B_CHK   = 4'd3;
  localparam logic [3:0] B_CMP   = 4'd4;
  localparam logic [3:0] N_I     = 4'd5;
  localparam logic [3:0] N_IRD   = 4'd6;
  localparam logic [3:0] N_J     = 4'd7;
  localparam logic [3:0] N_JRD   = 4'd8;
  localparam logic [3:0] N_MUL   = 4'd9;
  localparam logic [3:0] N_UNI   = 4'd10;
  localparam logic [3:0] N_THR   = 4'd11;
  localparam logic [3:0] N_CMP   = 4'd12;
  localparam logic [3:0] N_FLUSH = 4'd13;

  logic [3:0] state;

  bdn_pkg::cand_t mem [MAX_CANDIDATES];
  bdn_pkg::cand_t rd, wdata, cur, pend;
  logic [AW-1:0]  raddr, waddr;
  logic           we;

  logic                      cur_last, ovf, pend_v;
  logic [CW-1:0]             k, km1, fill, i, j;
  logic [KW-1:0]             kept;
  logic [MAX_CANDIDATES-1:0] supp;
  bdn_pkg::box_t             boxa, boxb;
  logic [15:0]               ix, iy, ix_c, iy_c;
  logic [31:0]               inter, area_a, area_b;
  logic [32:0]               uni;
  logic [48:0]               prod;
  logic [3:0]                done_state;

  function automatic logic [15:0] span(input logic [15:0] a0, input logic [15:0] as,
                                       input logic [15:0] b0, input logic [15:0] bs);
    logic [16:0] lo, hi, ae, be;
    ae = {1'b0, a0} + {1'b0, as};
    be = {1'b0, b0} + {1'b0, bs};
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (ae < be) ? ae : be;
    span = (hi > lo) ? 16'(hi - lo) : 16'd0;
  endfunction

  assign km1  = k - 1'b1;
  assign ix_c = span(boxa.x, boxa.w, rd.box.x, rd.box.w);
  assign iy_c = span(boxa.y, boxa.h, rd.box.y, rd.box.h);
  assign q_pop = (state == B_IDLE) && !q_empty;
  assign done_state = cur_last ? N_I : B_IDLE;

  always_comb begin
    raddr = '0;
    waddr = k[AW-1:0];
    we    = 1'b0;
    wdata = cur;
    case (state)
      B_FULL: raddr = AW'(MAX_CANDIDATES - 1);
      B_CHK: begin
        if (k == '0) we = 1'b1;
        else raddr = km1[AW-1:0];
      end
      B_CMP: begin
        we = 1'b1;
        if (rd.score < cur.score) wdata = rd;
      end
      N_I:     raddr = i[AW-1:0];
      N_J:     raddr = j[AW-1:0];
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      fill      <= '0;
      ovf       <= 1'b0;
      supp      <= '0;
      pend_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        B_IDLE: if (!q_empty) begin
          cur      <= q_item.cand;
          cur_last <= q_item.last;
          i        <= '0;
          kept     <= '0;
          if (!q_item.keep) begin
            state <= N_I;
          end else if (fill == CW'(MAX_CANDIDATES)) begin
            ovf   <= 1'b1;
            state <= B_FULL;
          end else begin
            k     <= fill;
            fill  <= fill + 1'b1;
            state <= B_CHK;
          end
        end
        B_FULL: state <= B_FCMP;
        B_FCMP: begin
          // a new box that ranks last in a full store (ties too) is dropped
          if (rd.score >= cur.score) begin
            state <= done_state;
          end else begin
            k     <= CW'(MAX_CANDIDATES - 1);
            state <= B_CHK;
          end
        end
        B_CHK: state <= (k == '0) ? done_state : B_CMP;
        B_CMP: begin
          if (rd.score < cur.score) begin
            k     <= km1;
            state <= B_CHK;
          end else begin
            state <= done_state;
          end
        end
        N_I: begin
          if (i == fill || kept == KW'(bdn_pkg::RESULT_LIMIT)) state <= N_FLUSH;
          else if (supp[i[AW-1:0]]) i <= i + 1'b1;
          else state <= N_IRD;
        end
        N_IRD: begin
          // a pick is sent out once the next one is known, so the last one can be marked
          if (pend_v) begin
            res_valid <= 1'b1;
            res.cand  <= pend;
            res.last  <= 1'b0;
            res.nodet <= 1'b0;
            res.ovf   <= ovf;
          end
          boxa   <= rd.box;
          pend   <= rd;
          pend_v <= 1'b1;
          kept   <= kept + 1'b1;
          j      <= i + 1'b1;
          state  <= N_J;
        end
        N_J: begin
          if (j == fill) begin
            i     <= i + 1'b1;
            state <= N_I;
          end else if (supp[j[AW-1:0]]) begin
            j <= j + 1'b1;
          end else begin
            state <= N_JRD;
          end
        end
        N_JRD: begin
          boxb  <= rd.box;
          ix    <= ix_c;
          iy    <= iy_c;
          state <= N_MUL;
        end
        N_MUL: begin
          inter  <= {16'b0, ix} * {16'b0, iy};
          area_a <= {16'b0, boxa.w} * {16'b0, boxa.h};
          area_b <= {16'b0, boxb.w} * {16'b0, boxb.h};
          state  <= N_UNI;
        end
        N_UNI: begin
          uni   <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};
          state <= N_THR;
        end
        N_THR: begin
          prod  <= {33'b0, cfg.overlap_threshold} * {16'b0, uni};
          state <= N_CMP;
        end
        N_CMP: begin
          if (uni != '0 && {1'b0, inter, 16'h0} > prod) supp[j[AW-1:0]] <= 1'b1;
          j     <= j + 1'b1;
          state <= N_J;
        end
        N_FLUSH: begin
          res_valid <= 1'b1;
          res.last  <= 1'b1;
          res.ovf   <= ovf;
          if (pend_v) begin
            res.cand  <= pend;
            res.nodet <= 1'b0;
          end else begin
            res.cand  <= '0;
            res.nodet <= 1'b1;
          end
          fill   <= '0;
          ovf    <= 1'b0;
          supp   <= '0;
          pend_v <= 1'b0;
          state  <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
